// File: design/gtq_pkg.sv
// ----------------------------------------------------------------------------
// gtq_pkg
// Shared constants and controller/datapath interface types for the grouped
// team queue.
// ----------------------------------------------------------------------------
package gtq_pkg;

  localparam int CAPACITY   = 256;
  localparam int GROUPS     = 16;
  localparam int TIME_BITS  = 32;

  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int GRP_W      = $clog2(GROUPS);
  localparam int GCNT_W     = $clog2(GROUPS + 1);
  localparam int TBIT_W     = $clog2(TIME_BITS);
  localparam int ID_W       = 16;
  localparam int PERIOD_W   = 8;
  localparam int DATA_W     = ID_W + TIME_BITS;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(2);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 88;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic enq;
    logic deq_rd;
    logic deq_fin;
    logic cfg_wr;
    logic mod_step;
  } gtq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dep_due;
    logic queue_empty;
    logic mod_last;
  } gtq_sts_t;

endpackage

// File: design/gtq_ram.sv
// ----------------------------------------------------------------------------
// gtq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/gtq_ctrl.sv
// ----------------------------------------------------------------------------
// gtq_ctrl
// Sequencer for the grouped team queue: accepts a request, runs the enqueue
// and departure steps, presents the result and handles period updates.
// ----------------------------------------------------------------------------
module gtq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  output gtq_pkg::gtq_cmd_t cmd,
  input  gtq_pkg::gtq_sts_t sts
);
  import gtq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_DEQ_RD,
    ST_DEQ_FIN,
    ST_OUT,
    ST_MOD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  assign cfg_ready  = (state_r == ST_IDLE);
  assign in_tready  = (state_r == ST_IDLE) && !cfg_valid;
  assign out_tvalid = out_tvalid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
          state_nxt  = ST_MOD;
        end else if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_ENQ;
        end
      end
      ST_ENQ: begin
        cmd.enq = 1'b1;
        if (sts.dep_due) begin
          state_nxt = ST_DEQ_RD;
        end else begin
          state_nxt      = ST_OUT;
          out_tvalid_nxt = 1'b1;
        end
      end
      ST_DEQ_RD: begin
        if (sts.queue_empty) begin
          state_nxt      = ST_OUT;
          out_tvalid_nxt = 1'b1;
        end else begin
          cmd.deq_rd = 1'b1;
          state_nxt  = ST_DEQ_FIN;
        end
      end
      ST_DEQ_FIN: begin
        cmd.deq_fin    = 1'b1;
        state_nxt      = ST_OUT;
        out_tvalid_nxt = 1'b1;
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt      = ST_IDLE;
          out_tvalid_nxt = 1'b0;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt      = ST_IDLE;
        out_tvalid_nxt = 1'b0;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

// File: design/gtq_dp.sv
// ----------------------------------------------------------------------------
// gtq_dp
// Datapath of the grouped team queue: minute and period tracking, slot
// stores, free-slot stack, per-group runs and the group-order ring.
// ----------------------------------------------------------------------------
module gtq_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gtq_pkg::gtq_cmd_t               cmd,
  output gtq_pkg::gtq_sts_t               sts,
  input  logic                            in_arrival_valid,
  input  logic [gtq_pkg::ID_W-1:0]        in_member_id,
  input  logic [gtq_pkg::GRP_W-1:0]       in_group_index,
  input  logic [gtq_pkg::PERIOD_W-1:0]    cfg_period,
  output logic                            res_departed,
  output logic                            res_dropped,
  output logic [gtq_pkg::ID_W-1:0]        res_id,
  output logic [gtq_pkg::GRP_W-1:0]       res_group,
  output logic [gtq_pkg::TIME_BITS-1:0]   res_entry,
  output logic [gtq_pkg::TIME_BITS-1:0]   res_exit
);
  import gtq_pkg::*;

  // Timing state.
  logic [PERIOD_W-1:0]  period_r;
  logic [TIME_BITS-1:0] minute_r, minute_nxt;
  logic [PERIOD_W-1:0]  rem_r, rem_nxt;
  logic [PERIOD_W:0]    rem_inc;
  logic                 first_r;
  logic                 dep_due_r, dep_due_nxt;

  // Period remainder unit.
  logic [PERIOD_W:0]    mod_rem_r, mod_t;
  logic [TBIT_W-1:0]    mod_cnt_r;

  // Latched request.
  logic                 arr_r;
  logic [ID_W-1:0]      id_r;
  logic [GRP_W-1:0]     grp_r;
  logic                 use_stack_r;

  // Slot allocation.
  logic [CNT_W-1:0]     fresh_r;
  logic [CNT_W-1:0]     sc_r;
  logic [CNT_W-1:0]     sc_dec;
  logic [SLOT_W-1:0]    stack_rdata;
  logic [SLOT_W-1:0]    s_alloc;
  logic                 enq_ok;

  // Group runs and order ring.
  logic [SLOT_W-1:0]    head_r [GROUPS];
  logic [SLOT_W-1:0]    tail_r [GROUPS];
  logic [GROUPS-1:0]    nonempty_r;
  logic [GRP_W-1:0]     ring_r [GROUPS];
  logic [GRP_W-1:0]     front_r, back_r;
  logic [GCNT_W-1:0]    count_r;

  // Departure scratch.
  logic [GRP_W-1:0]     deq_g_r;
  logic [SLOT_W-1:0]    deq_s_r;
  logic                 deq_last_r;
  logic [DATA_W-1:0]    data_rdata;
  logic [SLOT_W-1:0]    next_rdata;

  // Result registers.
  logic                 res_departed_r, res_dropped_r;
  logic [ID_W-1:0]      res_id_r;
  logic [GRP_W-1:0]     res_group_r;
  logic [TIME_BITS-1:0] res_entry_r, res_exit_r;

  assign res_departed = res_departed_r;
  assign res_dropped  = res_dropped_r;
  assign res_id       = res_id_r;
  assign res_group    = res_group_r;
  assign res_entry    = res_entry_r;
  assign res_exit     = res_exit_r;

  assign sts.dep_due     = dep_due_r;
  assign sts.queue_empty = (count_r == '0);
  assign sts.mod_last    = (mod_cnt_r == '0);

  // Minute advance and remainder of the minute by the period.
  always_comb begin
    minute_nxt = first_r ? minute_r + TIME_BITS'(1) : '0;
    rem_inc    = {1'b0, rem_r} + (PERIOD_W + 1)'(1);
    if (!first_r || minute_nxt == '0) begin
      rem_nxt = '0;
    end else if (rem_inc == {1'b0, period_r}) begin
      rem_nxt = '0;
    end else begin
      rem_nxt = rem_inc[PERIOD_W-1:0];
    end
    dep_due_nxt = (period_r != '0) && (minute_nxt != '0) && (rem_nxt == '0);
  end

  // One restoring step of minute modulo period.
  always_comb begin
    mod_t = {mod_rem_r[PERIOD_W-1:0], minute_r[mod_cnt_r]};
    if (mod_t >= {1'b0, period_r}) begin
      mod_t = mod_t - {1'b0, period_r};
    end
  end

  // Allocation choice.
  assign sc_dec  = sc_r - CNT_W'(1);
  assign enq_ok  = arr_r && (use_stack_r || (fresh_r < CNT_W'(CAPACITY)));
  assign s_alloc = use_stack_r ? stack_rdata : fresh_r[SLOT_W-1:0];

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= PERIOD_RESET;
      minute_r   <= '0;
      rem_r      <= '0;
      first_r    <= 1'b0;
      dep_due_r  <= 1'b0;
      mod_cnt_r  <= '0;
      fresh_r    <= '0;
      sc_r       <= '0;
      nonempty_r <= '0;
      front_r    <= '0;
      back_r     <= '0;
      count_r    <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        period_r  <= cfg_period;
        mod_cnt_r <= TBIT_W'(TIME_BITS - 1);
      end
      if (cmd.mod_step) begin
        mod_cnt_r <= mod_cnt_r - TBIT_W'(1);
        if (mod_cnt_r == '0) begin
          rem_r <= mod_t[PERIOD_W-1:0];
        end
      end
      if (cmd.accept) begin
        minute_r  <= minute_nxt;
        rem_r     <= rem_nxt;
        first_r   <= 1'b1;
        dep_due_r <= dep_due_nxt;
      end
      if (cmd.enq && enq_ok) begin
        if (use_stack_r) begin
          sc_r <= sc_dec;
        end else begin
          fresh_r <= fresh_r + CNT_W'(1);
        end
        if (!nonempty_r[grp_r]) begin
          nonempty_r[grp_r] <= 1'b1;
          if (count_r < GCNT_W'(GROUPS)) begin
            back_r  <= back_r + GRP_W'(1);
            count_r <= count_r + GCNT_W'(1);
          end
        end
      end
      if (cmd.deq_fin) begin
        sc_r <= sc_r + CNT_W'(1);
        if (deq_last_r) begin
          nonempty_r[deq_g_r] <= 1'b0;
          front_r             <= front_r + GRP_W'(1);
          count_r             <= count_r - GCNT_W'(1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.cfg_wr) begin
      mod_rem_r <= '0;
    end else if (cmd.mod_step) begin
      mod_rem_r <= mod_t;
    end
    if (cmd.accept) begin
      arr_r          <= in_arrival_valid;
      id_r           <= in_member_id;
      grp_r          <= in_group_index;
      use_stack_r    <= (sc_r != '0);
      res_departed_r <= 1'b0;
      res_dropped_r  <= 1'b0;
      res_id_r       <= '0;
      res_group_r    <= '0;
      res_entry_r    <= '0;
      res_exit_r     <= '0;
    end
    if (cmd.enq) begin
      res_dropped_r <= arr_r && !enq_ok;
      if (enq_ok) begin
        tail_r[grp_r] <= s_alloc;
        if (!nonempty_r[grp_r]) begin
          head_r[grp_r] <= s_alloc;
          if (count_r < GCNT_W'(GROUPS)) begin
            ring_r[back_r] <= grp_r;
          end
        end
      end
    end
    if (cmd.deq_rd) begin
      deq_g_r    <= ring_r[front_r];
      deq_s_r    <= head_r[ring_r[front_r]];
      deq_last_r <= (head_r[ring_r[front_r]] == tail_r[ring_r[front_r]]);
    end
    if (cmd.deq_fin) begin
      res_departed_r <= 1'b1;
      res_id_r       <= data_rdata[ID_W-1:0];
      res_group_r    <= deq_g_r;
      res_entry_r    <= data_rdata[DATA_W-1:ID_W];
      res_exit_r     <= minute_r;
      if (!deq_last_r) begin
        head_r[deq_g_r] <= next_rdata;
      end
    end
  end

  // Member id and entry minute per slot.
  gtq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data_ram (
    .clk   (clk),
    .we    (cmd.enq && enq_ok),
    .waddr (s_alloc),
    .wdata ({minute_r, id_r}),
    .raddr (head_r[ring_r[front_r]]),
    .rdata (data_rdata)
  );

  // Link to the next slot of the same group.
  gtq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (cmd.enq && enq_ok && nonempty_r[grp_r]),
    .waddr (tail_r[grp_r]),
    .wdata (s_alloc),
    .raddr (head_r[ring_r[front_r]]),
    .rdata (next_rdata)
  );

  // Stack of released slots.
  gtq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.deq_fin),
    .waddr (sc_r[SLOT_W-1:0]),
    .wdata (deq_s_r),
    .raddr (sc_dec[SLOT_W-1:0]),
    .rdata (stack_rdata)
  );

endmodule

// File: design/grouped_team_queue_unit.sv
// The sequencer accepts a request and enqueues the arrival; when a departure
// falls due on a non-empty queue it reads and releases the front member,
// then presents the result. One request at a time: no new one is accepted
// until the result is taken, as the sequencer steps through the shared
// slot memories. A period write runs a bit-serial remainder of the minute.
// Reset (rst_n, synchronous, active low) empties the queue, sets the minute
// to zero and the departure period to 2; no clearing pass is needed.
// ----------------------------------------------------------------------------
// grouped_team_queue_unit
// Team queue driven by minute ticks, with periodic departures from the
// front group.
// ----------------------------------------------------------------------------
module grouped_team_queue_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // member_id [15:0], group_index [19:16], zero [23:20]
  input  logic [gtq_pkg::IN_DATA_W-1:0]       in_tdata,
  // arrival_valid [0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // leaving_id [15:0], leaving_group [19:16], entry_minute [51:20],
  // exit_minute [83:52], zero [87:84]
  output logic [gtq_pkg::OUT_DATA_W-1:0]      out_tdata,
  // departed [0], arrival_dropped [1]
  output logic [1:0]                          out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gtq_pkg::PERIOD_W-1:0]        cfg_data
);
  import gtq_pkg::*;

  gtq_cmd_t             cmd;
  gtq_sts_t             sts;
  logic                 res_departed, res_dropped;
  logic [ID_W-1:0]      res_id;
  logic [GRP_W-1:0]     res_group;
  logic [TIME_BITS-1:0] res_entry, res_exit;

  // Result packing.
  assign out_tdata = {4'b0, res_exit, res_entry, res_group, res_id};
  assign out_tuser = {res_dropped, res_departed};

  gtq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  gtq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_arrival_valid (in_tuser),
    .in_member_id     (in_tdata[ID_W-1:0]),
    .in_group_index   (in_tdata[ID_W+GRP_W-1:ID_W]),
    .cfg_period       (cfg_data),
    .res_departed     (res_departed),
    .res_dropped      (res_dropped),
    .res_id           (res_id),
    .res_group        (res_group),
    .res_entry        (res_entry),
    .res_exit         (res_exit)
  );

endmodule

// File: test/tb_grouped_team_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped team queue unit testbench
// Drives minute ticks with random arrivals through the input stream. A
// behavioural copy of the queue works out the record due for each tick, and
// every record on the result stream is checked against it field by field.
// The departure period is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_grouped_team_queue_unit;
  import gtq_pkg::*;

  // Record due for one minute tick.
  typedef struct {
    bit        departed;
    bit [15:0] leaving_id;
    bit [3:0]  leaving_group;
    bit [31:0] entry_minute;
    bit [31:0] exit_minute;
    bit        arrival_dropped;
  } tick_rec_t;

  // Team queue model and store of records still due from the block.
  class team_queue_board;
    bit [15:0]       member_id_of [CAPACITY];
    bit [31:0]       stamp_of [CAPACITY];
    int              link_of [CAPACITY];
    int              free_list [CAPACITY];
    int              free_total;
    int              head_of [GROUPS];
    int              tail_of [GROUPS];
    bit              busy_group [GROUPS];
    int              ring [GROUPS];
    int              ring_front, ring_back, ring_fill;
    bit [31:0]       minute;
    bit              started;
    bit [7:0]        period;
    tick_rec_t       due_recs [$];
    int              fails;

    function new();
      for (int i = 0; i < CAPACITY; i++) free_list[i] = i;
      free_total = CAPACITY;
      period = PERIOD_RESET;
    endfunction

    // Works out the record for one accepted tick.
    function void note_tick(bit arrives, bit [15:0] id, bit [3:0] grp);
      tick_rec_t r;
      int s, g;
      r = '{default: 0};
      if (started) minute = minute + 1;
      else started = 1;
      if (arrives) begin
        if (free_total == 0) begin
          r.arrival_dropped = 1;
        end else begin
          free_total--;
          s = free_list[free_total];
          member_id_of[s] = id;
          stamp_of[s] = minute;
          link_of[s] = 0;
          if (busy_group[grp]) begin
            link_of[tail_of[grp]] = s;
            tail_of[grp] = s;
          end else begin
            head_of[grp] = s;
            tail_of[grp] = s;
            busy_group[grp] = 1;
            ring[ring_back] = grp;
            ring_back = (ring_back + 1) % GROUPS;
            ring_fill++;
          end
        end
      end
      if (period != 0 && minute != 0 && minute % period == 0 && ring_fill > 0) begin
        g = ring[ring_front];
        s = head_of[g];
        r.departed = 1;
        r.leaving_id = member_id_of[s];
        r.leaving_group = g[3:0];
        r.entry_minute = stamp_of[s];
        r.exit_minute = minute;
        if (head_of[g] == tail_of[g]) begin
          busy_group[g] = 0;
          ring_front = (ring_front + 1) % GROUPS;
          ring_fill--;
        end else begin
          head_of[g] = link_of[s];
        end
        free_list[free_total] = s;
        free_total++;
      end
      due_recs.insert(due_recs.size(), r);
    endfunction

    // Compares one result request with the oldest record due.
    function void check_result(bit [OUT_DATA_W-1:0] d, bit [1:0] u);
      tick_rec_t r;
      if (due_recs.size() == 0) begin
        $error("result with no tick outstanding");
        fails++;
        return;
      end
      r = due_recs.pop_front();
      if (u[0] !== r.departed) begin
        $error("departed: expected %0d, got %0d", r.departed, u[0]);
        fails++;
      end
      if (u[1] !== r.arrival_dropped) begin
        $error("arrival_dropped: expected %0d, got %0d", r.arrival_dropped, u[1]);
        fails++;
      end
      if (d[15:0] !== r.leaving_id) begin
        $error("leaving_id: expected %0h, got %0h", r.leaving_id, d[15:0]);
        fails++;
      end
      if (d[19:16] !== r.leaving_group) begin
        $error("leaving_group: expected %0d, got %0d", r.leaving_group, d[19:16]);
        fails++;
      end
      if (d[51:20] !== r.entry_minute) begin
        $error("entry_minute: expected %0d, got %0d", r.entry_minute, d[51:20]);
        fails++;
      end
      if (d[83:52] !== r.exit_minute) begin
        $error("exit_minute: expected %0d, got %0d", r.exit_minute, d[83:52]);
        fails++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [PERIOD_W-1:0]   cfg_data;

  team_queue_board board;
  bit              steady_flow;
  int              cycle_count;

  grouped_team_queue_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Run limit, well above the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: checks each accepted result, stalls at random, and holds
  // off once for a long stretch so that the block backs up.
  initial begin : result_side
    int own_cycles;
    int hold_left;
    own_cycles = 0;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
      own_cycles++;
      if (own_cycles == 3000) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady_flow || ($urandom_range(99) >= 29);
      end
    end
  end

  // Offers one tick and returns at the edge where it is accepted.
  task automatic send_tick(bit arrives, bit [15:0] id, bit [3:0] grp);
    while (!steady_flow && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= arrives;
    in_tdata <= {4'b0, grp, id};
    do @(posedge clk); while (!in_tready);
    board.note_tick(arrives, id, grp);
  endtask

  // Waits for every record due, then lets the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.due_recs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Writes the departure period while the block is idle.
  task automatic write_period(bit [7:0] p);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= p;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.period = p;
  endtask

  // Random ticks; narrow_groups keeps all arrivals in groups 0 to 3.
  task automatic random_ticks(int count, int arrive_pct, bit narrow_groups);
    bit [3:0] g;
    for (int i = 0; i < count; i++) begin
      g = narrow_groups ? 4'($urandom_range(3)) : 4'($urandom_range(15));
      send_tick($urandom_range(99) < arrive_pct, 16'($urandom), g);
    end
  endtask

  initial begin
    board = new();
    steady_flow = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-queue departures and extreme ids and groups.
    send_tick(0, 16'h0000, 4'd0);
    send_tick(0, 16'h0000, 4'd0);
    send_tick(0, 16'h0000, 4'd0);
    send_tick(1, 16'hFFFF, 4'd15);
    send_tick(1, 16'h0000, 4'd0);
    send_tick(1, 16'hA5A5, 4'd15);
    send_tick(1, 16'h5A5A, 4'd0);
    send_tick(1, 16'h1234, 4'd7);
    send_tick(1, 16'h8001, 4'd8);
    for (int i = 0; i < 8; i++) send_tick(0, 16'h0000, 4'd0);
    send_tick(1, 16'hBEEF, 4'd3);
    send_tick(1, 16'hCAFE, 4'd3);

    write_period(8'd1);
    send_tick(1, 16'h0F0F, 4'd9);
    send_tick(1, 16'hF0F0, 4'd9);
    send_tick(0, 16'h0000, 4'd0);
    send_tick(0, 16'h0000, 4'd0);

    // Steady stretch at the fastest departure rate.
    steady_flow = 1;
    random_ticks(150, 70, 0);
    steady_flow = 0;
    random_ticks(100, 90, 1);

    // Slowest rate: the store fills and arrivals are refused.
    write_period(8'd255);
    random_ticks(320, 95, 0);

    // No departures at all.
    write_period(8'd0);
    random_ticks(40, 50, 0);

    write_period(8'd3);
    random_ticks(120, 60, 1);

    // Fast departures free up slots in the store again.
    write_period(8'd1);
    random_ticks(120, 40, 0);

    drain();
    repeat (20) @(posedge clk);
    if (board.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/gtq_pkg.sv
design/gtq_ram.sv
design/gtq_ctrl.sv
design/gtq_dp.sv
design/grouped_team_queue_unit.sv
test/tb_grouped_team_queue_unit.sv
